// ===== rtl/core/in_order_release_buffer_defines.svh =====
//------------------------------------------------------------------------------
// in_order_release_buffer_defines
// Assertion macros used by the checker of the in-order release buffer.
//------------------------------------------------------------------------------
`ifndef IN_ORDER_RELEASE_BUFFER_DEFINES_SVH
`define IN_ORDER_RELEASE_BUFFER_DEFINES_SVH

// concurrent check, off while reset is asserted
`define IORB_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent check that also holds during reset
`define IORB_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/iorb_pkg.sv =====
//------------------------------------------------------------------------------
// iorb_pkg
// Types and constants of the in-order release buffer.
//------------------------------------------------------------------------------
package iorb_pkg;

  localparam int unsigned DefDepth     = 32;
  localparam int unsigned DefDataWidth = 32;

  localparam int unsigned IndexW    = 32;
  localparam int unsigned PayloadW  = 32;
  localparam int unsigned InTdataW  = IndexW + PayloadW;
  localparam int unsigned InTuserW  = 2;
  localparam int unsigned OutTdataW = IndexW + PayloadW;
  localparam int unsigned OutTuserW = 2;

  typedef enum logic {
    CmdRequest = 1'b0,
    CmdProvide = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KindRelease  = 2'd0,
    KindRange    = 2'd1,
    KindCapacity = 2'd2
  } kind_e;

endpackage

// ===== rtl/core/in_order_release_buffer.sv =====
//------------------------------------------------------------------------------
// in_order_release_buffer
// Reorder buffer that holds out-of-order results in a ring of DEPTH slots
// and releases them strictly in sequence order.
//------------------------------------------------------------------------------
// Usage: requests enter on the s_axis channel, one at a time. A request command
// widens the window end, a provide command stores a payload in its slot.
// Results leave on the m_axis channel: released items in sequence order, or
// one status result (index outside window, request beyond capacity). tlast
// marks the final result caused by one request.
// Timing: a request is taken in StIdle and then decoded in StExec.
// Widening the window clears each new slot in StReqClr. A provide whose index
// lies DEPTH or more past the window start (only after the start has wrapped)
// gets its slot modulo from StModA, StModB and StModC before StProv. A release
// run reads each item's slot in StWalkRd and checks it in StWalkChk.
// Reset: after rst_ni rises the slot memory is cleared in DEPTH cycles, one
// slot per cycle, with s_axis_tready low.
// Stall: a finished result waits in the output register; a release run pauses
// while it is full and m_axis_tready is low, and no new request is taken until the run ends.
//------------------------------------------------------------------------------
module in_order_release_buffer #(
  parameter int unsigned DEPTH      = iorb_pkg::DefDepth,
  parameter int unsigned DATA_WIDTH = iorb_pkg::DefDataWidth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // seq_index [31:0], payload [63:32]
  input  logic [iorb_pkg::InTdataW-1:0]   s_axis_tdata,
  // command [0], has_payload [1]
  input  logic [iorb_pkg::InTuserW-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_index [31:0], out_payload [63:32]
  output logic [iorb_pkg::OutTdataW-1:0]  m_axis_tdata,
  // kind [1:0]
  output logic [iorb_pkg::OutTuserW-1:0]  m_axis_tuser,
  output logic                            m_axis_tlast
);
  import iorb_pkg::*;

  localparam int unsigned SlotW  = $clog2(DEPTH);
  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned StoreW = (DATA_WIDTH < PayloadW) ? DATA_WIDTH : PayloadW;
  localparam int unsigned EntryW = StoreW + 1;
  localparam int unsigned ProdW  = 2 * IndexW + 1;

  // reciprocal for slot = index mod DEPTH, exact for all 32-bit indexes
  localparam logic [63:0]       RecipFull = ((64'd1 << (IndexW + SlotW)) / 64'(DEPTH)) + 64'd1;
  localparam logic [IndexW:0]   Recip     = RecipFull[IndexW:0];
  localparam logic [SlotW-1:0]  SlotMax   = SlotW'(DEPTH - 1);
  localparam logic [SlotW:0]    DepthS    = (SlotW + 1)'(DEPTH);
  localparam logic [IndexW-1:0] DepthI    = IndexW'(DEPTH);
  localparam logic [CntW-1:0]   DepthC    = CntW'(DEPTH);

  localparam logic [3:0] StClear   = 4'd0;
  localparam logic [3:0] StIdle    = 4'd1;
  localparam logic [3:0] StExec    = 4'd2;
  localparam logic [3:0] StReqClr  = 4'd3;
  localparam logic [3:0] StModA    = 4'd4;
  localparam logic [3:0] StModB    = 4'd5;
  localparam logic [3:0] StModC    = 4'd6;
  localparam logic [3:0] StProv    = 4'd7;
  localparam logic [3:0] StWalkRd  = 4'd8;
  localparam logic [3:0] StWalkChk = 4'd9;

  function automatic logic [SlotW-1:0] slot_inc(input logic [SlotW-1:0] s);
    return (s == SlotMax) ? '0 : s + SlotW'(1);
  endfunction

  logic [3:0]        state_q, state_d;
  logic [IndexW-1:0] start_q, start_d, end_q, end_d;
  logic [SlotW-1:0]  start_slot_q, start_slot_d, end_slot_q, end_slot_d;

  cmd_e              cmd_q, cmd_d;
  logic [IndexW-1:0] idx_q, idx_d;
  logic [StoreW-1:0] pay_q, pay_d;
  logic              has_q, has_d;

  logic [SlotW-1:0]  sweep_slot_q, sweep_slot_d;
  logic [SlotW-1:0]  sweep_cnt_q, sweep_cnt_d;

  logic [ProdW-1:0]  prod_q, prod_d;
  logic [IndexW-1:0] qd_q, qd_d;
  logic [SlotW-1:0]  mslot_q, mslot_d;

  logic [IndexW:0]   walk_j_q, walk_j_d;
  logic [SlotW-1:0]  walk_slot_q, walk_slot_d;
  logic [CntW-1:0]   walk_cnt_q, walk_cnt_d;
  logic [IndexW-1:0] pend_idx_q, pend_idx_d;
  logic [StoreW-1:0] pend_pay_q, pend_pay_d;

  logic                out_valid_q, out_valid_d;
  kind_e               out_kind_q, out_kind_d;
  logic [IndexW-1:0]   out_idx_q, out_idx_d;
  logic [PayloadW-1:0] out_pay_q, out_pay_d;
  logic                out_last_q, out_last_d;

  // slot memory: filled flag on top of the payload
  logic [EntryW-1:0] mem_q [DEPTH];
  logic [EntryW-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [SlotW-1:0]  mem_waddr, mem_raddr;
  logic [EntryW-1:0] mem_wdata;

  logic              out_free, push;
  kind_e             push_kind;
  logic [IndexW-1:0] push_idx;
  logic [PayloadW-1:0] push_pay;
  logic              push_last;

  logic              prov_go;
  logic [SlotW-1:0]  prov_slot;

  logic [IndexW-1:0] off;
  logic [SlotW:0]    fast_sum;
  logic [SlotW-1:0]  fast_slot;
  logic              in_window;
  logic [IndexW:0]   req_span;
  logic [IndexW-1:0] quo, rem;
  logic              walk_cont;

  assign s_axis_tready = (state_q == StIdle);
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    off       = idx_q - start_q;
    fast_sum  = {1'b0, start_slot_q} + {1'b0, off[SlotW-1:0]};
    fast_slot = (fast_sum >= DepthS) ? SlotW'(fast_sum - DepthS) : fast_sum[SlotW-1:0];
    in_window = !(idx_q > end_q) && !(idx_q < start_q);
    req_span  = {1'b0, idx_q} - {1'b0, start_q};
    quo       = IndexW'(prod_q >> (IndexW + SlotW));
    rem       = idx_q - qd_q;
    walk_cont = (walk_j_q <= {1'b0, end_q}) && (walk_cnt_q < DepthC) && rdata_q[StoreW];
  end

  always_comb begin
    state_d      = state_q;
    start_d      = start_q;
    end_d        = end_q;
    start_slot_d = start_slot_q;
    end_slot_d   = end_slot_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    pay_d        = pay_q;
    has_d        = has_q;
    sweep_slot_d = sweep_slot_q;
    sweep_cnt_d  = sweep_cnt_q;
    prod_d       = prod_q;
    qd_d         = qd_q;
    mslot_d      = mslot_q;
    walk_j_d     = walk_j_q;
    walk_slot_d  = walk_slot_q;
    walk_cnt_d   = walk_cnt_q;
    pend_idx_d   = pend_idx_q;
    pend_pay_d   = pend_pay_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = walk_slot_q;
    push         = 1'b0;
    push_kind    = KindRelease;
    push_idx     = idx_q;
    push_pay     = '0;
    push_last    = 1'b1;
    prov_go      = 1'b0;
    prov_slot    = fast_slot;

    unique case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_slot_q;
        if (sweep_slot_q == SlotMax) begin
          sweep_slot_d = '0;
          state_d      = StIdle;
        end else begin
          sweep_slot_d = sweep_slot_q + SlotW'(1);
        end
      end
      StIdle: begin
        if (s_axis_tvalid) begin
          cmd_d   = cmd_e'(s_axis_tuser[0]);
          has_d   = s_axis_tuser[1];
          idx_d   = s_axis_tdata[IndexW-1:0];
          pay_d   = s_axis_tdata[IndexW +: StoreW];
          state_d = StExec;
        end
      end
      StExec: begin
        if (cmd_q == CmdRequest) begin
          if (idx_q < end_q) begin
            state_d = StIdle;
          end else if (req_span >= (IndexW + 1)'(DEPTH)) begin
            if (out_free) begin
              push      = 1'b1;
              push_kind = KindCapacity;
              state_d   = StIdle;
            end
          end else begin
            end_d = idx_q;
            if (idx_q == end_q) begin
              state_d = StIdle;
            end else begin
              sweep_slot_d = slot_inc(end_slot_q);
              sweep_cnt_d  = SlotW'(idx_q - end_q);
              state_d      = StReqClr;
            end
          end
        end else begin
          if (!in_window) begin
            if (out_free) begin
              push      = 1'b1;
              push_kind = KindRange;
              state_d   = StIdle;
            end
          end else if (!has_q) begin
            state_d = StIdle;
          end else if (off < DepthI) begin
            prov_go = 1'b1;
          end else begin
            state_d = StModA;
          end
        end
      end
      StReqClr: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_slot_q;
        if (sweep_cnt_q == SlotW'(1)) begin
          end_slot_d = sweep_slot_q;
          state_d    = StIdle;
        end else begin
          sweep_slot_d = slot_inc(sweep_slot_q);
          sweep_cnt_d  = sweep_cnt_q - SlotW'(1);
        end
      end
      StModA: begin
        prod_d  = ProdW'(idx_q) * ProdW'(Recip);
        state_d = StModB;
      end
      StModB: begin
        qd_d    = quo * DepthI;
        state_d = StModC;
      end
      StModC: begin
        mslot_d = (rem >= DepthI) ? SlotW'(rem - DepthI) : rem[SlotW-1:0];
        state_d = StProv;
      end
      StProv: begin
        prov_go   = 1'b1;
        prov_slot = mslot_q;
      end
      StWalkRd: begin
        mem_re    = 1'b1;
        mem_raddr = walk_slot_q;
        state_d   = StWalkChk;
      end
      StWalkChk: begin
        if (out_free) begin
          push      = 1'b1;
          push_kind = KindRelease;
          push_idx  = pend_idx_q;
          push_pay  = PayloadW'(pend_pay_q);
          push_last = !walk_cont;
          if (walk_cont) begin
            mem_we      = 1'b1;
            mem_waddr   = walk_slot_q;
            mem_wdata   = {1'b0, rdata_q[StoreW-1:0]};
            pend_idx_d  = walk_j_q[IndexW-1:0];
            pend_pay_d  = rdata_q[StoreW-1:0];
            walk_j_d    = walk_j_q + (IndexW + 1)'(1);
            walk_slot_d = slot_inc(walk_slot_q);
            walk_cnt_d  = walk_cnt_q + CntW'(1);
            state_d     = StWalkRd;
          end else begin
            start_d      = walk_j_q[IndexW-1:0];
            // start wrapped to zero: its slot is zero, not the walked one
            start_slot_d = walk_j_q[IndexW] ? '0 : walk_slot_q;
            if (end_q < walk_j_q[IndexW-1:0]) begin
              mem_we     = 1'b1;
              mem_waddr  = walk_slot_q;
              end_d      = walk_j_q[IndexW-1:0];
              end_slot_d = walk_slot_q;
            end
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (prov_go) begin
      mem_we    = 1'b1;
      mem_waddr = prov_slot;
      if (idx_q == start_q) begin
        // the head slot is released at once, so it is stored already empty
        mem_wdata   = {1'b0, pay_q};
        pend_idx_d  = idx_q;
        pend_pay_d  = pay_q;
        walk_j_d    = {1'b0, idx_q} + (IndexW + 1)'(1);
        walk_slot_d = slot_inc(prov_slot);
        walk_cnt_d  = CntW'(1);
        state_d     = StWalkRd;
      end else begin
        mem_wdata = {1'b1, pay_q};
        state_d   = StIdle;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_idx_d   = out_idx_q;
    out_pay_d   = out_pay_q;
    out_last_d  = out_last_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_kind_d  = push_kind;
      out_idx_d   = push_idx;
      out_pay_d   = push_pay;
      out_last_d  = push_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      start_q      <= '0;
      end_q        <= '0;
      start_slot_q <= '0;
      end_slot_q   <= '0;
      sweep_slot_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      start_q      <= start_d;
      end_q        <= end_d;
      start_slot_q <= start_slot_d;
      end_slot_q   <= end_slot_d;
      sweep_slot_q <= sweep_slot_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    idx_q       <= idx_d;
    pay_q       <= pay_d;
    has_q       <= has_d;
    sweep_cnt_q <= sweep_cnt_d;
    prod_q      <= prod_d;
    qd_q        <= qd_d;
    mslot_q     <= mslot_d;
    walk_j_q    <= walk_j_d;
    walk_slot_q <= walk_slot_d;
    walk_cnt_q  <= walk_cnt_d;
    pend_idx_q  <= pend_idx_d;
    pend_pay_q  <= pend_pay_d;
    out_kind_q  <= out_kind_d;
    out_idx_q   <= out_idx_d;
    out_pay_q   <= out_pay_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_pay_q, out_idx_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/core/iorb_checker.sv =====
//------------------------------------------------------------------------------
// iorb_checker
// Port-level checks of the in-order release buffer, bound to the top level.
//------------------------------------------------------------------------------
`include "in_order_release_buffer_defines.svh"

module iorb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [iorb_pkg::InTdataW-1:0]   s_axis_tdata,
  input logic [iorb_pkg::InTuserW-1:0]   s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [iorb_pkg::OutTdataW-1:0]  m_axis_tdata,
  input logic [iorb_pkg::OutTuserW-1:0]  m_axis_tuser,
  input logic                            m_axis_tlast
);
  import iorb_pkg::*;

  logic status_out;
  logic in_unused;

  assign status_out = m_axis_tvalid && (m_axis_tuser != KindRelease);
  assign in_unused  = ^{s_axis_tdata, s_axis_tuser};

  // one request in flight: the port closes right after a request
  `IORB_ASSERT(a_one_request, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request taken while another is in flight")
  // a status result is always the only result of its request
  `IORB_ASSERT(a_status_last, clk_i, rst_ni, status_out |-> m_axis_tlast, "status result without tlast")
  `IORB_ASSERT(a_status_zero, clk_i, rst_ni, status_out |-> (m_axis_tdata[OutTdataW-1:IndexW] == '0), "status result with nonzero payload")
  `IORB_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")
  `IORB_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !s_axis_tready && !m_axis_tvalid && (in_unused || !in_unused), "ports active during reset")

endmodule

bind in_order_release_buffer iorb_checker u_iorb_checker (.*);

// ===== tb/sv/in_order_release_buffer_test.sv =====
//------------------------------------------------------------------------------
// in_order_release_buffer_test
// Self-checking bench for the in-order release buffer. A window tracker
// mirrors the buffer's window and slot state. It works out the released items
// and status results for every accepted request and checks the results that
// leave the block in order, field by field. Stimulus is a directed opening
// and then bursts that widen the window and fill it in shuffled order. Noise
// requests are mixed into the bursts. The run goes through several
// sender-idle and receiver-stall phases.
//------------------------------------------------------------------------------
module in_order_release_buffer_test;
  import iorb_pkg::*;

  localparam int unsigned Depth       = DefDepth;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 4 * Depth + 32;

  typedef struct {
    kind_e             kind;
    logic [IndexW-1:0] seq_idx;
    logic [PayloadW-1:0] data;
    logic              is_last;
  } release_result_t;

  // mirror of the window and the slot ring, plus the results still owed
  class window_tracker;
    logic [IndexW-1:0]   win_start;
    logic [IndexW-1:0]   win_end;
    bit                  filled [Depth];
    logic [PayloadW-1:0] slot_data [Depth];
    release_result_t     awaited [$];
    int unsigned         errors;

    function new();
      win_start = '0;
      win_end   = '0;
      foreach (filled[i]) filled[i] = 1'b0;
      errors = 0;
    endfunction

    function void apply_request(cmd_e cmd, logic [IndexW-1:0] idx,
                                logic [PayloadW-1:0] pay, bit has);
      logic [IndexW:0] walk;
      logic [IndexW:0] span;
      release_result_t res;
      int unsigned     n;
      if (cmd == CmdRequest) begin
        if (idx < win_end) return;
        span = {1'b0, idx} - {1'b0, win_start};
        if (span >= Depth) begin
          awaited.push_back(release_result_t'{KindCapacity, idx, '0, 1'b1});
          return;
        end
        for (walk = {1'b0, win_end} + 1'b1; walk <= {1'b0, idx}; walk++) begin
          filled[walk % Depth] = 1'b0;
        end
        win_end = idx;
        return;
      end
      if (idx > win_end || idx < win_start) begin
        awaited.push_back(release_result_t'{KindRange, idx, '0, 1'b1});
        return;
      end
      if (!has) return;
      slot_data[idx % Depth] = pay;
      filled[idx % Depth]    = 1'b1;
      if (idx != win_start) return;
      // walk the run of filled slots from the window start
      n    = 0;
      walk = {1'b0, win_start};
      while (walk <= {1'b0, win_end} && n < Depth && filled[walk % Depth]) begin
        res.kind    = KindRelease;
        res.seq_idx = walk[IndexW-1:0];
        res.data    = slot_data[walk % Depth];
        res.is_last = 1'b0;
        awaited.push_back(res);
        filled[walk % Depth] = 1'b0;
        n++;
        walk++;
      end
      if (n > 0) awaited[awaited.size() - 1].is_last = 1'b1;
      win_start = walk[IndexW-1:0];
      // window drained past its end: collapse it onto the new start
      if (win_end < win_start) begin
        filled[win_start % Depth] = 1'b0;
        win_end = win_start;
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task compare_result(logic [OutTuserW-1:0] kind, logic [IndexW-1:0] seq,
                        logic [PayloadW-1:0] data, logic last);
      release_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d index %h", kind, seq));
        return;
      end
      want = awaited.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("index %h kind %0d, want %0d", want.seq_idx, kind,
                                  want.kind));
      if (seq !== want.seq_idx)
        report_mismatch($sformatf("index %h, want %h", seq, want.seq_idx));
      if (data !== want.data)
        report_mismatch($sformatf("index %h payload %h, want %h", want.seq_idx, data,
                                  want.data));
      if (last !== want.is_last)
        report_mismatch($sformatf("index %h tlast %b, want %b", want.seq_idx, last,
                                  want.is_last));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic [InTuserW-1:0]  s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic [OutTuserW-1:0] m_axis_tuser;
  logic                 m_axis_tlast;

  window_tracker tracker;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  int unsigned   items_sent;
  int unsigned   cycles = 0;

  in_order_release_buffer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.compare_result(m_axis_tuser, m_axis_tdata[IndexW-1:0],
                             m_axis_tdata[OutTdataW-1:IndexW], m_axis_tlast);
    end
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("in_order_release_buffer_test: errors");
    $finish;
  end

  // entered and left at a falling edge; valid only drops when a gap is taken
  task automatic send_item(input cmd_e cmd, input logic [IndexW-1:0] idx,
                           input logic [PayloadW-1:0] pay, input bit has);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {pay, idx};
    s_axis_tuser  = {has, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.apply_request(cmd, idx, pay, has);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic run_directed();
    send_item(CmdProvide, 32'd0, $urandom, 1'b0);           // in window, no payload
    send_item(CmdProvide, 32'hFFFF_FFFF, 32'd0, 1'b1);      // far above end
    send_item(CmdProvide, 32'd1, $urandom, 1'b1);           // just above end
    send_item(CmdRequest, Depth, $urandom, 1'b1);           // one past capacity
    send_item(CmdRequest, 32'hFFFF_FFFF, $urandom, 1'b0);
    send_item(CmdRequest, 32'd3, $urandom, 1'b0);
    send_item(CmdRequest, 32'd2, $urandom, 1'b1);           // below end
    send_item(CmdProvide, 32'd2, 32'hFFFF_FFFF, 1'b1);      // not at start
    send_item(CmdProvide, 32'd2, 32'hA5A5_A5A5, 1'b1);      // overwrite
    send_item(CmdProvide, 32'd1, $urandom, 1'b0);
    send_item(CmdProvide, 32'd0, 32'd0, 1'b1);              // releases one
    send_item(CmdProvide, 32'd0, $urandom, 1'b1);           // below start
    send_item(CmdProvide, 32'd1, 32'h5A5A_5A5A, 1'b1);      // releases two
    send_item(CmdProvide, 32'd3, 32'hFFFF_FFFF, 1'b1);      // window empties
    send_item(CmdProvide, 32'd4, $urandom, 1'b0);
    send_item(CmdProvide, 32'd5, $urandom, 1'b1);
    send_item(CmdRequest, 32'd4 + Depth - 1, $urandom, 1'b0);  // full window
    send_item(CmdRequest, 32'd4 + Depth, $urandom, 1'b1);      // just over
    send_item(CmdProvide, 32'd4 + Depth - 1, 32'd1, 1'b1);
    send_item(CmdProvide, 32'd4, 32'd2, 1'b1);
  endtask

  task automatic send_noise();
    logic [IndexW-1:0] idx;
    case ($urandom_range(4))
      0: send_item(CmdRequest, tracker.win_start + $urandom_range(Depth, Depth + 8),
                   $urandom, 1'($urandom_range(1)));
      1: send_item(CmdRequest, $urandom, $urandom, 1'($urandom_range(1)));
      2: begin
        if (tracker.win_start != 0 && $urandom_range(1) == 0)
          idx = $urandom_range(tracker.win_start - 1, 0);
        else
          idx = $urandom;
        send_item(CmdProvide, idx, $urandom, 1'($urandom_range(1)));
      end
      3: send_item(CmdProvide,
                   tracker.win_start + $urandom_range(tracker.win_end - tracker.win_start),
                   $urandom, 1'b0);
      default: send_item(cmd_e'($urandom_range(1)), $urandom, $urandom,
                         1'($urandom_range(1)));
    endcase
  endtask

  // widen the window, then fill it in shuffled order
  task automatic run_burst(input bit full);
    logic [IndexW-1:0] order [$];
    logic [IndexW-1:0] tmp;
    int unsigned       span;
    int                k;
    int                j;
    int                first;
    span = full ? Depth : $urandom_range(1, Depth);
    send_item(CmdRequest, tracker.win_start + span - 1, $urandom, 1'($urandom_range(1)));
    for (k = 0; k <= int'(tracker.win_end - tracker.win_start); k++) begin
      order.push_back(tracker.win_start + k);
    end
    // often hold the start back so the whole window goes out in one run
    first = (full || $urandom_range(2) == 0) ? 1 : 0;
    for (k = order.size() - 1; k > first; k--) begin
      j = $urandom_range(k, first);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    if (first == 1) order.push_back(order.pop_front());
    foreach (order[i]) begin
      if ($urandom_range(11) == 0) send_noise();
      if ($urandom_range(19) == 0)
        send_item(CmdProvide, order[$urandom_range(i)], $urandom, 1'b1);
      send_item(CmdProvide, order[i], $urandom, (full || $urandom_range(19) != 0));
    end
  endtask

  initial begin
    int unsigned item_goal;
    bit          full;
    tracker        = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    rst_ni         = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    full = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 88;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 88;
        end
        default: begin
          send_idle_pct  = 24;
          recv_stall_pct = 24;
        end
      endcase
      // the goal is checked only between bursts, so the last burst of a phase runs past it
      item_goal = items_sent + 84;
      while (items_sent < item_goal) begin
        run_burst(full);
        full = ($urandom_range(7) == 0);
      end
    end
    s_axis_tvalid = 1'b0;

    while (tracker.awaited.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("in_order_release_buffer_test: clean");
    end else begin
      $display("in_order_release_buffer_test: errors");
    end
    $finish;
  end

endmodule
